>>> rtl/core/wcig_pkg.sv
// ----------------------------------------------------------------------------
// wcig_pkg
// Shared types and constants of the cipher IV generator: cipher codes, the
// registered transaction and the formatter result.
// ----------------------------------------------------------------------------
`default_nettype none

package wcig_pkg;

  // cipher codes, codes above ccmp are invalid
  typedef enum logic [2:0] {
    CIPHER_NONE   = 3'd0,
    CIPHER_WEP40  = 3'd1,
    CIPHER_WEP104 = 3'd2,
    CIPHER_TKIP   = 3'd3,
    CIPHER_CCMP   = 3'd4
  } cipher_e;

  // counter widths
  localparam int unsigned CtrW    = 48;
  localparam int unsigned WepCtrW = 24;

  // iv lengths in bytes
  localparam logic [3:0] IvLenNone = 4'd0;
  localparam logic [3:0] IvLenWep  = 4'd4;
  localparam logic [3:0] IvLenExt  = 4'd8;

  // weak iv filter and extended iv constants
  localparam logic [7:0]         WeakMid   = 8'hFF;
  localparam logic [8:0]         WeakLow   = 9'd3;
  localparam logic [WepCtrW-1:0] WeakStep  = 24'h000100;
  localparam logic [7:0]         ExtIvBit  = 8'h20;
  localparam logic [7:0]         TkipMask  = 8'h7F;

  // one registered transaction
  typedef struct packed {
    logic            mode;
    logic [2:0]      cipher;
    logic [1:0]      key_index;
    logic [3:0]      key_len;
    logic [CtrW-1:0] load_value;
  } item_t;

  // formatter result and counter write-back
  typedef struct packed {
    logic [63:0]     iv;
    logic [3:0]      len;
    logic            drop;
    logic            wr_en;
    logic [CtrW-1:0] wr_val;
  } fmt_res_t;

endpackage

`default_nettype wire

>>> rtl/core/wcig_ctr_store.sv
// ----------------------------------------------------------------------------
// wcig_ctr_store
// Per-slot sequence counter store with registered read, write-to-read
// forwarding and per-entry valid bits so unwritten counters read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wcig_ctr_store #(
  parameter  int unsigned NumSlots = 8,
  localparam int unsigned IdxW     = (NumSlots > 1) ? $clog2(NumSlots) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              rd_en_i,
  input  wire logic [IdxW-1:0]                   rd_idx_i,
  input  wire logic                              wr_en_i,
  input  wire logic [IdxW-1:0]                   wr_idx_i,
  input  wire logic [wcig_pkg::CtrW-1:0]         wr_data_i,
  output logic      [wcig_pkg::CtrW-1:0]         rd_data_o
);

  logic [wcig_pkg::CtrW-1:0] mem_q [NumSlots];
  logic [NumSlots-1:0]       vld_q;
  logic [wcig_pkg::CtrW-1:0] rd_q;
  logic                      rd_vld_q;

  // counter array write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_idx_i] <= 1'b1;
    end
  end

  // registered read, forwarding a same-cycle write to the same slot
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_idx_i == rd_idx_i)) begin
        rd_q     <= wr_data_i;
        rd_vld_q <= 1'b1;
      end else begin
        rd_q     <= mem_q[rd_idx_i];
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

>>> rtl/core/wcig_iv_fmt.sv
// ----------------------------------------------------------------------------
// wcig_iv_fmt
// Builds the WEP, TKIP or CCMP IV from the slot counter, applies weak IV
// skipping and computes the counter write-back (the load value in load mode).
// ----------------------------------------------------------------------------
`default_nettype none

module wcig_iv_fmt (
  input  wire wcig_pkg::item_t              item_i,
  input  wire logic [wcig_pkg::CtrW-1:0]    ctr_i,
  output wcig_pkg::fmt_res_t                res_o
);

  logic [wcig_pkg::WepCtrW-1:0] wep_s;
  logic [wcig_pkg::WepCtrW-1:0] wep_used;
  logic [7:0]                   wep_top;
  logic                         weak_iv;
  logic [7:0]                   key_byte;
  logic [wcig_pkg::CtrW-1:0]    ctr_inc;

  // weak iv detection on the low 24 counter bits
  always_comb begin
    wep_s   = ctr_i[wcig_pkg::WepCtrW-1:0];
    wep_top = wep_s[23:16];
    weak_iv = (wep_s[15:8] == wcig_pkg::WeakMid)
           && ({1'b0, wep_top} >= wcig_pkg::WeakLow)
           && ({1'b0, wep_top} < (wcig_pkg::WeakLow + {5'b0, item_i.key_len}));
    wep_used = weak_iv ? (wep_s + wcig_pkg::WeakStep) : wep_s;
    key_byte = {item_i.key_index, 6'b0} | wcig_pkg::ExtIvBit;
    ctr_inc  = ctr_i + {{(wcig_pkg::CtrW-1){1'b0}}, 1'b1};
  end

  // per-cipher iv layout and write-back
  always_comb begin
    res_o = '0;
    if (item_i.mode) begin
      res_o.wr_en  = 1'b1;
      res_o.wr_val = item_i.load_value;
    end else begin
      unique case (wcig_pkg::cipher_e'(item_i.cipher))
        wcig_pkg::CIPHER_NONE: begin
          res_o.len = wcig_pkg::IvLenNone;
        end
        wcig_pkg::CIPHER_WEP40, wcig_pkg::CIPHER_WEP104: begin
          res_o.iv     = {32'b0, item_i.key_index, 6'b0, wep_used[7:0],
                          wep_used[15:8], wep_used[23:16]};
          res_o.len    = wcig_pkg::IvLenWep;
          res_o.wr_en  = 1'b1;
          res_o.wr_val = {{(wcig_pkg::CtrW-wcig_pkg::WepCtrW){1'b0}},
                          wep_used + {{(wcig_pkg::WepCtrW-1){1'b0}}, 1'b1}};
        end
        wcig_pkg::CIPHER_TKIP: begin
          res_o.iv     = {ctr_i[47:16], key_byte, ctr_i[7:0],
                          (ctr_i[15:8] | wcig_pkg::ExtIvBit) & wcig_pkg::TkipMask,
                          ctr_i[15:8]};
          res_o.len    = wcig_pkg::IvLenExt;
          res_o.wr_en  = 1'b1;
          res_o.wr_val = ctr_inc;
        end
        wcig_pkg::CIPHER_CCMP: begin
          res_o.iv     = {ctr_i[47:16], key_byte, 8'b0, ctr_i[15:0]};
          res_o.len    = wcig_pkg::IvLenExt;
          res_o.wr_en  = 1'b1;
          res_o.wr_val = ctr_inc;
        end
        default: begin
          res_o.drop = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wifi_cipher_iv_generator.sv
// Pipeline: an accepted transaction passes the input register, then the result
// register; done_o rises in the same cycle as its result appears on the outputs.
// Throughput: one transaction per cycle; busy is never raised, and a frame on
// the same key slot as the one before is served by forwarding the counter
// write-back around the counter store's read register.
// Reset: all counters read as zero after reset via per-slot valid bits.
// ----------------------------------------------------------------------------
// wifi_cipher_iv_generator
// Transmit IV / packet number generator with one sequence counter per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module wifi_cipher_iv_generator #(
  parameter int unsigned KEY_SLOTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode_i,
  input  wire logic [2:0]  key_slot_i,
  input  wire logic [2:0]  cipher_i,
  input  wire logic [1:0]  key_index_i,
  input  wire logic [3:0]  wep_key_length_i,
  input  wire logic [47:0] load_value_i,
  output logic             done_o,
  output logic [63:0]      iv_bytes_o,
  output logic [3:0]       iv_length_o,
  output logic             drop_o
);

  localparam int unsigned SlotW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic                      accept;
  logic [SlotW-1:0]          slot_map [8];
  logic [SlotW-1:0]          slot_idx;
  logic                      s1_vld_q;
  wcig_pkg::item_t           s1_item_q;
  logic [SlotW-1:0]          s1_slot_q;
  logic [wcig_pkg::CtrW-1:0] ctr_rd;
  wcig_pkg::fmt_res_t        fmt_res;
  logic                      done_q;
  logic [63:0]               iv_q;
  logic [3:0]                len_q;
  logic                      drop_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // slot number folded into the configured slot count
  for (genvar g = 0; g < 8; g++) begin : g_slot_map
    assign slot_map[g] = SlotW'(g % KEY_SLOTS);
  end
  assign slot_idx = slot_map[key_slot_i];

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.mode       <= mode_i;
      s1_item_q.cipher     <= cipher_i;
      s1_item_q.key_index  <= key_index_i;
      s1_item_q.key_len    <= wep_key_length_i;
      s1_item_q.load_value <= load_value_i;
      s1_slot_q            <= slot_idx;
    end
  end

  // counter store, read at accept and written back from the formatter
  wcig_ctr_store #(
    .NumSlots (KEY_SLOTS)
  ) u_ctr_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_idx_i  (slot_idx),
    .wr_en_i   (s1_vld_q && fmt_res.wr_en),
    .wr_idx_i  (s1_slot_q),
    .wr_data_i (fmt_res.wr_val),
    .rd_data_o (ctr_rd)
  );

  // iv formatting
  wcig_iv_fmt u_iv_fmt (
    .item_i (s1_item_q),
    .ctr_i  (ctr_rd),
    .res_o  (fmt_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      iv_q   <= fmt_res.iv;
      len_q  <= fmt_res.len;
      drop_q <= fmt_res.drop;
    end
  end

  assign done_o      = done_q;
  assign iv_bytes_o  = iv_q;
  assign iv_length_o = len_q;
  assign drop_o      = drop_q;

  // checks
  a_accept_to_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_vld_q)
    else $error("accepted transaction did not reach the input register");

  a_stage_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |=> done_o)
    else $error("registered transaction produced no result strobe");

  a_len_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (iv_length_o == wcig_pkg::IvLenNone || iv_length_o == wcig_pkg::IvLenWep
                || iv_length_o == wcig_pkg::IvLenExt))
    else $error("illegal iv length");

  a_drop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && drop_o) |-> (iv_length_o == wcig_pkg::IvLenNone && iv_bytes_o == '0))
    else $error("dropped frame carries iv bytes");

  a_forward : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && fmt_res.wr_en && accept && (slot_idx == s1_slot_q))
    |=> (ctr_rd == $past(fmt_res.wr_val)))
    else $error("same-slot counter update not forwarded");

endmodule

`default_nettype wire
